[design/utf8u16_pkg.sv]
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// Used by the top level and by its port checker; depends on nothing else.
package utf8u16_pkg;

    localparam logic [1:0] STOP_NONE      = 2'd0;
    localparam logic [1:0] STOP_INVALID   = 2'd1;
    localparam logic [1:0] STOP_FULL      = 2'd2;
    localparam logic [1:0] STOP_TRUNCATED = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    localparam logic REG_BIG_ENDIAN = 1'b0;
    localparam logic REG_CAPACITY   = 1'b1;

    localparam logic [31:0] CP_HIGH_LOW_END  = 32'h0000_d7ff;
    localparam logic [31:0] CP_SURR_END      = 32'h0000_dfff;
    localparam logic [31:0] CP_BMP_END       = 32'h0000_ffff;
    localparam logic [31:0] CP_MAX           = 32'h0010_ffff;
    localparam logic [31:0] CP_SUPP_BASE     = 32'h0001_0000;
    localparam logic [5:0]  SURR_HIGH_PREFIX = 6'b110110;
    localparam logic [5:0]  SURR_LOW_PREFIX  = 6'b110111;

    function automatic logic [2:0] seq_length(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < 8'he0) begin
            len = (lead < 8'h80) ? 3'd1 : 3'd2;
        end else if (lead < 8'hf8) begin
            len = (lead < 8'hf0) ? 3'd3 : 3'd4;
        end else begin
            len = (lead < 8'hfc) ? 3'd5 : 3'd6;
        end
        return len;
    endfunction

endpackage

[design/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: decoder, state and output serializer.
// Depends on utf8u16_pkg.
//
// The block takes one UTF-8 byte per s_ beat and produces one result per m_ beat. An accepted
// byte is decoded in the cycle it is taken; its results (0, 2 or 4 data bytes, plus an end
// marker when s_tlast is set) are loaded into a small output buffer that is drained one beat per
// cycle while m_tready is high. A new byte is taken in the cycle the buffer drains its last beat
// or while the buffer is empty, so the buffer never holds the results of two bytes at once: the
// output serializer sets the rate at which bytes are taken.
// After reset the byte order is big endian and the output capacity is 65535 bytes.
module utf8_to_utf16_transcoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [9:8] stop_reason, [25:10] total_bytes
    output logic [0:0]  m_tuser,    // [0] kind
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CmpW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    logic                   big_endian_reg;
    logic [15:0]            capacity_reg;
    logic [31:0]            acc_reg, acc_next;
    logic [2:0]             remain_reg, remain_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   stopped_reg, stopped_next;
    logic [1:0]             cause_reg, cause_next;

    logic [7:0]             byte_reg [4];
    logic [2:0]             left_reg;
    logic [1:0]             pos_reg;
    logic                   marker_reg;
    logic [1:0]             reason_reg;
    logic [COUNT_WIDTH-1:0] total_reg;

    logic [7:0]             new_bytes [4];
    logic [2:0]             new_ndata;
    logic [1:0]             new_reason;
    logic [COUNT_WIDTH-1:0] new_total;

    logic                   accept;
    logic                   out_fire;
    logic [2:0]             data_left;
    logic                   beat_is_marker;
    logic [15:0]            total16;

    always_comb begin
        logic [2:0]  len;
        logic        fin;
        logic [2:0]  n;
        logic [31:0] v;
        logic [15:0] unit0, unit1;
        logic [CmpW-1:0] sum;

        len          = utf8u16_pkg::seq_length(s_tdata);
        fin          = 1'b0;
        n            = 3'd0;
        v            = acc_reg;
        unit0        = 16'd0;
        unit1        = 16'd0;
        sum          = '0;
        acc_next     = acc_reg;
        remain_next  = remain_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        cause_next   = cause_reg;
        new_ndata    = 3'd0;
        new_reason   = utf8u16_pkg::STOP_NONE;

        if (!stopped_reg) begin
            if (remain_reg == 3'd0) begin
                if (CmpW'(count_reg) >= CmpW'(capacity_reg)) begin
                    stopped_next = 1'b1;
                    cause_next   = utf8u16_pkg::STOP_FULL;
                end else begin
                    acc_next    = {24'd0, s_tdata & (8'hff >> len)};
                    remain_next = len - 3'd1;
                    fin         = (len == 3'd1);
                end
            end else begin
                acc_next    = {acc_reg[25:0], s_tdata[5:0]};
                remain_next = remain_reg - 3'd1;
                fin         = (remain_reg == 3'd1);
            end

            if (fin) begin
                if (acc_next <= utf8u16_pkg::CP_HIGH_LOW_END) begin
                    n = 3'd2;
                end else if (acc_next <= utf8u16_pkg::CP_SURR_END) begin
                    n = 3'd0;
                end else if (acc_next <= utf8u16_pkg::CP_BMP_END) begin
                    n = 3'd2;
                end else if (acc_next <= utf8u16_pkg::CP_MAX) begin
                    n = 3'd4;
                end else begin
                    n = 3'd0;
                end
                sum = CmpW'(count_reg) + CmpW'(n);
                if (n == 3'd0) begin
                    stopped_next = 1'b1;
                    cause_next   = utf8u16_pkg::STOP_INVALID;
                end else if (sum > CmpW'(capacity_reg)) begin
                    stopped_next = 1'b1;
                    cause_next   = utf8u16_pkg::STOP_FULL;
                end else begin
                    new_ndata  = n;
                    count_next = COUNT_WIDTH'(count_reg + COUNT_WIDTH'(n));
                    if (n == 3'd4) begin
                        v     = acc_next - utf8u16_pkg::CP_SUPP_BASE;
                        unit0 = {utf8u16_pkg::SURR_HIGH_PREFIX, v[19:10]};
                        unit1 = {utf8u16_pkg::SURR_LOW_PREFIX, v[9:0]};
                    end else begin
                        unit0 = acc_next[15:0];
                    end
                end
            end
            if (stopped_next) begin
                remain_next = 3'd0;
            end
        end

        new_bytes[0] = big_endian_reg ? unit0[15:8] : unit0[7:0];
        new_bytes[1] = big_endian_reg ? unit0[7:0]  : unit0[15:8];
        new_bytes[2] = big_endian_reg ? unit1[15:8] : unit1[7:0];
        new_bytes[3] = big_endian_reg ? unit1[7:0]  : unit1[15:8];
        new_total    = (new_ndata != 3'd0) ? COUNT_WIDTH'(count_reg + COUNT_WIDTH'(1))
                                           : count_reg;

        if (s_tlast) begin
            if (stopped_next) begin
                new_reason = cause_next;
            end else if (remain_next != 3'd0) begin
                new_reason = utf8u16_pkg::STOP_TRUNCATED;
            end
        end
    end

    assign data_left      = left_reg - {2'd0, marker_reg};
    assign beat_is_marker = marker_reg && (left_reg == 3'd1);
    assign m_tvalid       = (left_reg != 3'd0);
    assign out_fire       = m_tvalid && m_tready;
    assign s_tready       = (left_reg == 3'd0) || ((left_reg == 3'd1) && m_tready);
    assign accept         = s_tvalid && s_tready;
    assign cfg_ready      = 1'b1;
    assign total16        = 16'(total_reg);

    assign m_tdata = {6'd0, total16,
                      beat_is_marker ? reason_reg : utf8u16_pkg::STOP_NONE,
                      beat_is_marker ? 8'd0 : byte_reg[pos_reg]};
    assign m_tuser = beat_is_marker ? utf8u16_pkg::KIND_MARKER : utf8u16_pkg::KIND_DATA;
    assign m_tlast = (left_reg == 3'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b1;
            capacity_reg   <= 16'hffff;
            acc_reg        <= '0;
            remain_reg     <= '0;
            count_reg      <= '0;
            stopped_reg    <= 1'b0;
            cause_reg      <= utf8u16_pkg::STOP_NONE;
            left_reg       <= '0;
            pos_reg        <= '0;
            marker_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    utf8u16_pkg::REG_BIG_ENDIAN: big_endian_reg <= cfg_data[0];
                    utf8u16_pkg::REG_CAPACITY:   capacity_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                if (s_tlast) begin
                    acc_reg     <= '0;
                    remain_reg  <= '0;
                    count_reg   <= '0;
                    stopped_reg <= 1'b0;
                    cause_reg   <= utf8u16_pkg::STOP_NONE;
                end else begin
                    acc_reg     <= acc_next;
                    remain_reg  <= remain_next;
                    count_reg   <= count_next;
                    stopped_reg <= stopped_next;
                    cause_reg   <= cause_next;
                end
                left_reg   <= new_ndata + {2'd0, s_tlast};
                pos_reg    <= '0;
                marker_reg <= s_tlast;
            end else if (out_fire) begin
                left_reg <= left_reg - 3'd1;
                pos_reg  <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg   <= new_bytes;
            reason_reg <= new_reason;
            total_reg  <= new_total;
        end else if (out_fire && (data_left >= 3'd2)) begin
            total_reg <= COUNT_WIDTH'(total_reg + COUNT_WIDTH'(1));
        end
    end

endmodule

[design/utf8u16_checker.sv]
// Port checker for the UTF-8 to UTF-16 transcoder, bound to its top level.
// Depends on utf8u16_pkg and on the port list of utf8_to_utf16_transcoder.
module utf8u16_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("Input stalled while no result beat is pending.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == utf8u16_pkg::KIND_MARKER))
            |-> (m_tlast && (m_tdata[7:0] == 8'd0)))
        else $error("End marker is not the final beat or carries a data byte.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == utf8u16_pkg::KIND_DATA))
            |-> (m_tdata[9:8] == utf8u16_pkg::STOP_NONE))
        else $error("Data beat carries a stop reason.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("Result group broken off before its last beat.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("Stalled result beat changed.");

endmodule

bind utf8_to_utf16_transcoder utf8u16_checker u_utf8u16_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
